// File: hdl/pattern_occurrence_counter_unit_defines.svh
// Assertion macros for the pattern occurrence counter
`ifndef PATTERN_OCCURRENCE_COUNTER_UNIT_DEFINES_SVH
`define PATTERN_OCCURRENCE_COUNTER_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define POC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pattern_occurrence_counter_unit: assertion failed");

// next-cycle implication
`define POC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pattern_occurrence_counter_unit: assertion failed");

`else

`define POC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define POC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/poc_pkg.sv
// Shared types and constants of the pattern occurrence counter
package poc_pkg;

  localparam int WORD_W      = 32;
  localparam int CFG_W       = 5;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    MODE_PATTERN = 1'b0,
    MODE_TEXT    = 1'b1
  } mode_t;

  typedef struct packed {
    logic              is_text;
    logic              last;
    logic [WORD_W-1:0] word;
  } cmd_t;

endpackage

// File: hdl/poc_front.sv
// Front end: accepts items, classifies them and assigns pattern store slots
module poc_front #(
  parameter int PATTERN_MAX = 16,
  parameter int IDX_W       = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [poc_pkg::WORD_W-1:0] in_tdata,
  input  logic                      in_tuser,
  input  logic                      in_tlast,
  input  logic                      cfg_we,
  input  logic                      q_full,
  output logic                      q_push,
  output poc_pkg::cmd_t             q_cmd,
  output logic [IDX_W-1:0]          q_slot
);

  logic [IDX_W-1:0] load_pos_r;
  logic [IDX_W-1:0] load_pos_nxt;
  poc_pkg::mode_t   mode;

  assign mode      = poc_pkg::mode_t'(in_tuser);
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_cmd.is_text = (mode == poc_pkg::MODE_TEXT);
    q_cmd.last    = (mode == poc_pkg::MODE_TEXT) && in_tlast;
    q_cmd.word    = in_tdata;
    q_slot        = load_pos_r;
  end

  // advance the load slot on each pattern item, wrapping at the store depth; a config write returns it to slot 0
  always_comb begin
    load_pos_nxt = load_pos_r;
    if (cfg_we) begin
      load_pos_nxt = '0;
    end else if (q_push && (mode == poc_pkg::MODE_PATTERN)) begin
      if (load_pos_r == IDX_W'(PATTERN_MAX - 1)) begin
        load_pos_nxt = '0;
      end else begin
        load_pos_nxt = load_pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
    end else begin
      load_pos_r <= load_pos_nxt;
    end
  end

endmodule

// File: hdl/poc_queue.sv
// Short queue between front end and back end
module poc_queue #(
  parameter int DATA_W = 37
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              rd_valid,
  output logic [DATA_W-1:0] rd_data
);

  localparam int PTR_W = (poc_pkg::QUEUE_DEPTH > 1) ? $clog2(poc_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(poc_pkg::QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_r [poc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == CNT_W'(poc_pkg::QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(poc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(poc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: hdl/poc_back.sv
// Back end: pattern store, text window, compare stage and count/result stage
`include "pattern_occurrence_counter_unit_defines.svh"

module poc_back #(
  parameter int PATTERN_MAX = 16,
  parameter int COUNT_BITS  = 16,
  parameter int IDX_W       = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [poc_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  poc_pkg::cmd_t              q_cmd,
  input  logic [IDX_W-1:0]           q_slot,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [COUNT_BITS-1:0]      out_count
);

  localparam int FILL_W = $clog2(PATTERN_MAX + 1);

  logic [poc_pkg::CFG_W-1:0]  len_r;
  logic [poc_pkg::WORD_W-1:0] pat_r  [PATTERN_MAX];
  logic [poc_pkg::WORD_W-1:0] tw_r   [PATTERN_MAX];
  logic [poc_pkg::WORD_W-1:0] tw_nxt [PATTERN_MAX];
  logic [FILL_W-1:0]          fill_r;
  logic [FILL_W-1:0]          fill_nxt;
  logic [FILL_W-1:0]          fill_inc;
  logic [FILL_W-1:0]          len_use;
  logic [PATTERN_MAX-1:0]     lane_ok;
  logic                       match;
  logic                       en;
  logic                       take;
  logic                       take_text;

  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic                       s1_match_r;
  logic                       s1_last_r;
  logic [COUNT_BITS-1:0]      total_r;
  logic [COUNT_BITS-1:0]      total_nxt;
  logic [COUNT_BITS-1:0]      total_inc;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [COUNT_BITS-1:0]      out_data_r;

  // hold the back end pipeline while a result waits
  assign en        = !out_valid_r || out_ready;
  assign take      = en && q_valid;
  assign take_text = take && q_cmd.is_text;
  assign q_pop     = take;
  assign out_valid = out_valid_r;
  assign out_count = out_data_r;

  always_comb begin
    if (len_r == '0) begin
      len_use = FILL_W'(1);
    end else if (32'(len_r) > PATTERN_MAX) begin
      len_use = FILL_W'(PATTERN_MAX);
    end else begin
      len_use = FILL_W'(len_r);
    end
  end

  always_comb begin
    tw_nxt[0] = q_cmd.word;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      tw_nxt[k] = tw_r[k-1];
    end
  end

  assign fill_inc = (fill_r == FILL_W'(PATTERN_MAX)) ? fill_r : fill_r + 1'b1;

  // pattern slot j lines up with the word that is len_use-1-j items old
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (FILL_W'(j) < len_use) begin
        lane_ok[j] = (tw_nxt[IDX_W'(len_use - FILL_W'(1) - FILL_W'(j))] == pat_r[j]);
      end else begin
        lane_ok[j] = 1'b1;
      end
    end
  end

  assign match = (&lane_ok) && (fill_inc >= len_use);

  always_comb begin
    fill_nxt     = fill_r;
    s1_valid_nxt = s1_valid_r;
    if (en) begin
      s1_valid_nxt = take_text;
    end
    if (take_text) begin
      fill_nxt = q_cmd.last ? '0 : fill_inc;
    end
  end

  always_comb begin
    total_inc = (s1_match_r && (total_r != {COUNT_BITS{1'b1}})) ? total_r + 1'b1 : total_r;
    total_nxt = total_r;
    out_valid_nxt = out_valid_r;
    if (en) begin
      out_valid_nxt = s1_valid_r && s1_last_r;
      if (s1_valid_r) begin
        total_nxt = s1_last_r ? '0 : total_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !q_cmd.is_text) begin
      pat_r[q_slot] <= q_cmd.word;
    end
    if (take_text) begin
      tw_r       <= tw_nxt;
      s1_match_r <= match;
      s1_last_r  <= q_cmd.last;
    end
    if (en && s1_valid_r && s1_last_r) begin
      out_data_r <= total_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= poc_pkg::CFG_W'(1);
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
      fill_r      <= fill_nxt;
      s1_valid_r  <= s1_valid_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `POC_ASSERT_IMP(a_result_from_last, clk, rst_n, $rose(out_valid_r), $past(s1_valid_r && s1_last_r))
  `POC_ASSERT_NXT(a_total_cleared, clk, rst_n, en && s1_valid_r && s1_last_r, total_r == '0)
  `POC_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_W'(PATTERN_MAX))

endmodule

// File: hdl/pattern_occurrence_counter_unit.sv
// Pattern occurrence counter: top level
// A last text item's result passes through the queue, compare and result stages.
// Throughput: one item per cycle while the result side takes results.
// A two-entry queue lets the input side run on while the back end is stalled.
// Reset (rst_n low, synchronous): pattern length 1, load slot 0, window empty, count zero.
// The pattern store is not cleared by reset.
module pattern_occurrence_counter_unit #(
  parameter int PATTERN_MAX = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [poc_pkg::WORD_W-1:0]          in_tdata,   // [31:0] element
  input  logic                                in_tuser,   // [0] mode
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((COUNT_BITS+7)/8)*8-1:0]     out_tdata,  // [COUNT_BITS-1:0] occurrence_count
  input  logic                                cfg_we,
  input  logic [poc_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int OUT_W  = ((COUNT_BITS + 7) / 8) * 8;
  localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CMD_W  = $bits(poc_pkg::cmd_t);
  localparam int DATA_W = IDX_W + CMD_W;

  logic                  q_full;
  logic                  q_push;
  poc_pkg::cmd_t         push_cmd;
  logic [IDX_W-1:0]      push_slot;
  logic                  q_pop;
  logic                  q_valid;
  logic [DATA_W-1:0]     q_rd_data;
  poc_pkg::cmd_t         pop_cmd;
  logic [IDX_W-1:0]      pop_slot;
  logic [COUNT_BITS-1:0] count;

  poc_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .q_slot    (push_slot)
  );

  poc_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_slot, push_cmd}),
    .full      (q_full),
    .pop       (q_pop),
    .rd_valid  (q_valid),
    .rd_data   (q_rd_data)
  );

  assign pop_cmd  = poc_pkg::cmd_t'(q_rd_data[CMD_W-1:0]);
  assign pop_slot = q_rd_data[DATA_W-1:CMD_W];

  poc_back #(
    .PATTERN_MAX (PATTERN_MAX),
    .COUNT_BITS  (COUNT_BITS),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (pop_cmd),
    .q_slot    (pop_slot),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_count (count)
  );

  assign out_tdata = OUT_W'(count);

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the pattern occurrence counter unit
module testbench;

  localparam int PAT_DEPTH   = 16;
  localparam int DIR_ROWS    = 21;
  localparam int RAND_ITEMS  = 1150;
  localparam int SETTLE      = 6;
  localparam int CYCLE_LIMIT = 800000;

  typedef enum logic {
    ROW_CFG,
    ROW_ITEM
  } row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    poc_pkg::mode_t  mode;
    logic [31:0]     word;
    logic            last;
    int              reps;
    int              known;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] element
  logic        in_tuser = 1'b0; // [0] mode
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] occurrence_count
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  pattern_occurrence_counter_unit #(
    .PATTERN_MAX(PAT_DEPTH),
    .COUNT_BITS (16)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // counter model state
  logic [31:0] pat_mem [PAT_DEPTH];
  logic [31:0] win [PAT_DEPTH];
  int unsigned load_slot = 0;
  int unsigned win_count = 0;
  logic [4:0]  len_reg = 5'd1;
  logic [15:0] hits = '0;

  logic [15:0] expected_counts [$];
  int unsigned n_errors = 0;
  int unsigned cycle_count = 0;
  int          gap_odds = 4;
  int          stall_odds = 4;
  int          stall_left = 0;
  logic [31:0] sym_a, sym_b;
  plan_row_t   plan [DIR_ROWS];

  function automatic int unsigned len_in_use();
    if (len_reg == 0) return 1;
    if (len_reg > PAT_DEPTH) return PAT_DEPTH;
    return len_reg;
  endfunction

  function automatic bit step_counter(input poc_pkg::mode_t m, input logic [31:0] w,
                                      input logic l, output logic [15:0] cnt);
    int unsigned n;
    int          k;
    bit          hit;
    cnt = '0;
    if (m == poc_pkg::MODE_PATTERN) begin
      pat_mem[load_slot] = w;
      load_slot = (load_slot + 1) % PAT_DEPTH;
      return 1'b0;
    end
    for (k = PAT_DEPTH - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = w;
    if (win_count < PAT_DEPTH) win_count++;
    n = len_in_use();
    hit = (win_count >= n);
    for (k = 0; k < n; k++) begin
      if (win[k] != pat_mem[n-1-k]) hit = 1'b0;
    end
    if (hit && hits != 16'hFFFF) hits++;
    if (!l) return 1'b0;
    cnt = hits;
    for (k = 0; k < PAT_DEPTH; k++) win[k] = '0;
    win_count = 0;
    hits = '0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] alphabet_word();
    return $urandom_range(0, 1) ? sym_a : sym_b;
  endfunction

  task automatic send_item(input poc_pkg::mode_t m, input logic [31:0] w, input logic l,
                           input int known);
    logic [15:0] cnt;
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= w;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    if (step_counter(m, w, l, cnt)) expected_counts.push_back(known >= 0 ? known[15:0] : cnt);
  endtask

  task automatic maybe_gap();
    if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(input logic [4:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_reg   = v;
    load_slot = 0;
  endtask

  always @(posedge clk) begin
    if (stall_odds == 0) begin
      stall_left <= 0;
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, stall_odds) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, out_tdata);
        n_errors++;
      end else begin
        if (out_tdata !== expected_counts[0]) begin
          $display("%0t: occurrence_count mismatch, expected %0d, actual %0d",
                   $time, expected_counts[0], out_tdata);
          n_errors++;
        end
        void'(expected_counts.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] txt [$];
    int unsigned rand_items;
    int unsigned n, tl, r, k, i;
    logic [4:0]  v;

    for (k = 0; k < PAT_DEPTH; k++) begin
      pat_mem[k] = '0;
      win[k]     = '0;
    end
    rand_items = 0;
    plan = '{
      '{ROW_ITEM, poc_pkg::MODE_PATTERN, 32'h8000_0000, 1'b0, 1, -1},
      '{ROW_ITEM, poc_pkg::MODE_TEXT,    32'h8000_0000, 1'b1, 1,  1},
      '{ROW_ITEM, poc_pkg::MODE_TEXT,    32'h7FFF_FFFF, 1'b1, 1,  0},
      '{ROW_ITEM, poc_pkg::MODE_TEXT,    32'h8000_0000, 1'b0, 2, -1},
      '{ROW_ITEM, poc_pkg::MODE_TEXT,    32'h8000_0000, 1'b1, 1,  3},
      '{ROW_CFG,  poc_pkg::MODE_PATTERN, 32'd0,         1'b0, 1, -1},
      '{ROW_ITEM, poc_pkg::MODE_PATTERN, 32'hFFFF_FFFF, 1'b1, 1, -1},
      '{ROW_ITEM, poc_pkg::MODE_TEXT,    32'hFFFF_FFFF, 1'b1, 1,  1},
      '{ROW_CFG,  poc_pkg::MODE_PATTERN, 32'd2,         1'b0, 1, -1},
      '{ROW_ITEM, poc_pkg::MODE_PATTERN, 32'd5,         1'b0, 1, -1},
      '{ROW_ITEM, poc_pkg::MODE_PATTERN, 32'd5,         1'b0, 1, -1},
      '{ROW_ITEM, poc_pkg::MODE_TEXT,    32'd5,         1'b1, 1,  0},
      '{ROW_ITEM, poc_pkg::MODE_TEXT,    32'd5,         1'b0, 2, -1},
      '{ROW_ITEM, poc_pkg::MODE_TEXT,    32'd5,         1'b1, 1,  2},
      '{ROW_ITEM, poc_pkg::MODE_TEXT,    32'h7FFF_FFFF, 1'b0, 1, -1},
      '{ROW_ITEM, poc_pkg::MODE_PATTERN, 32'd0,         1'b0, 1, -1},
      '{ROW_ITEM, poc_pkg::MODE_TEXT,    32'd5,         1'b1, 1, -1},
      '{ROW_CFG,  poc_pkg::MODE_PATTERN, 32'd1,         1'b0, 1, -1},
      '{ROW_ITEM, poc_pkg::MODE_PATTERN, 32'd0,         1'b0, 1, -1},
      '{ROW_ITEM, poc_pkg::MODE_TEXT,    32'd0,         1'b0, 4, -1},
      '{ROW_ITEM, poc_pkg::MODE_TEXT,    32'd0,         1'b1, 1,  5}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_length(plan[i].word[4:0]);
      end else begin
        repeat (plan[i].reps) begin
          if (plan[i].reps == 1) maybe_gap();
          send_item(plan[i].mode, plan[i].word, plan[i].last, plan[i].known);
        end
      end
    end

    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      if (rand_items + 150 > RAND_ITEMS) begin
        gap_odds   = 0;
        stall_odds <= 0;
      end else begin
        gap_odds   = $urandom_range(0, 2) * 4;
        stall_odds <= $urandom_range(0, 2) * 4;
      end
      case ($urandom_range(0, 7))
        0: v = 5'd0;
        1: v = 5'd1;
        2: v = 5'd16;
        3: v = 5'd31;
        4: v = 5'($urandom_range(17, 30));
        default: v = 5'($urandom_range(1, 6));
      endcase
      write_length(v);
      n = len_in_use();
      sym_a = $urandom;
      sym_b = $urandom;
      for (k = 0; k < n; k++) begin
        maybe_gap();
        send_item(poc_pkg::MODE_PATTERN, alphabet_word(), 1'($urandom_range(0, 1)), -1);
        rand_items++;
      end
      repeat ($urandom_range(1, 3)) begin
        txt.delete();
        tl = $urandom_range(1, 2 * n + 10);
        while (txt.size() < tl) begin
          r = $urandom_range(0, 19);
          if (r < 4) begin
            for (k = 0; k < n; k++) txt.push_back(pat_mem[k]);
          end else if (r == 4) begin
            txt.push_back($urandom);
          end else begin
            txt.push_back(alphabet_word());
          end
        end
        for (k = 0; k < txt.size(); k++) begin
          if ($urandom_range(0, 29) == 0) begin
            maybe_gap();
            send_item(poc_pkg::MODE_PATTERN, alphabet_word(), 1'($urandom_range(0, 1)), -1);
            rand_items++;
          end
          maybe_gap();
          send_item(poc_pkg::MODE_TEXT, txt[k], k == txt.size() - 1, -1);
          rand_items++;
        end
      end
    end

    wait_idle();
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
